### rtl/core/slmc_pkg.sv
`default_nettype none

package slmc_pkg;

  localparam int unsigned MV_W      = 13;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SETTING_W = 16;
  localparam int unsigned MODE_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SETTING_W-1:0] SETTING_RESET = 16'd3300;
  localparam logic [SETTING_W-1:0] SETTING_MIN   = 16'd1800;
  localparam logic [SETTING_W-1:0] SETTING_MAX   = 16'd5000;
  localparam logic [12:0]          MV_FULL_SCALE = 13'd6600;
  localparam logic [16:0]          SAMPLE_MAX    = 17'd65535;
  localparam logic [31:0]          RECIP_TEN     = 32'd52429;

  typedef enum logic [2:0] {
    KIND_TICK          = 3'd0,
    KIND_TX_NOTICE     = 3'd1,
    KIND_RX_NOTICE     = 3'd2,
    KIND_SET_RUNNING   = 3'd3,
    KIND_SET_CONNECTED = 3'd4
  } slmc_kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF       = 4'd0,
    MODE_RUNNING   = 4'd1,
    MODE_CONNECTED = 4'd2,
    MODE_ANY_BLINK = 4'd3,
    MODE_POWER     = 4'd4,
    MODE_VREF      = 4'd5,
    MODE_TX        = 4'd6,
    MODE_RX        = 4'd7,
    MODE_TXRX      = 4'd8
  } slmc_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFERENCE_SETTING_MV = 2'd0,
    CFG_LED_ONE_MODE         = 2'd1,
    CFG_LED_TWO_MODE         = 2'd2
  } slmc_cfg_idx_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [15:0]         byte_count;
    logic                flag_value;
    logic [SAMPLE_W-1:0] adc_sample;
    logic                adc_valid;
  } slmc_in_t;

  typedef struct packed {
    logic            led_one_on;
    logic            led_two_on;
    logic [MV_W-1:0] external_mv;
    logic            reference_good;
  } slmc_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SETTING_W-1:0] wdata;
  } slmc_cfg_t;

  typedef struct packed {
    logic running;
    logic connected;
    logic ref_on;
    logic blink;
    logic tx;
    logic rx;
  } slmc_led_src_t;

  // sample * 6600 / 65535, floor; x / 65535 = hi + ((hi + lo) >= 65535)
  function automatic logic [MV_W-1:0] sample_to_mv(input logic [SAMPLE_W-1:0] sample);
    logic [28:0] prod;
    logic [16:0] sum;
    prod = 29'(sample) * 29'(MV_FULL_SCALE);
    sum  = 17'(prod[28:16]) + 17'(prod[15:0]);
    return prod[28:16] + MV_W'(sum >= SAMPLE_MAX);
  endfunction

  function automatic logic [12:0] clamp_setting(input logic [SETTING_W-1:0] v);
    logic [SETTING_W-1:0] c;
    if (v < SETTING_MIN) begin
      c = SETTING_MIN;
    end else if (v > SETTING_MAX) begin
      c = SETTING_MAX;
    end else begin
      c = v;
    end
    return c[12:0];
  endfunction

  // floor(set * 90 / 100) = floor(set * 9 / 10)
  function automatic logic [MV_W-1:0] on_threshold(input logic [SETTING_W-1:0] v);
    logic [15:0] n9;
    logic [31:0] p;
    n9 = 16'(clamp_setting(v)) * 16'd9;
    p  = 32'(n9) * RECIP_TEN;
    return p[31:19];
  endfunction

  // floor(set * 85 / 100) = floor(floor(set * 17 / 4) / 5)
  function automatic logic [MV_W-1:0] off_threshold(input logic [SETTING_W-1:0] v);
    logic [16:0] n17;
    logic [31:0] p;
    n17 = 17'(clamp_setting(v)) * 17'd17;
    p   = 32'(n17[16:2]) * RECIP_TEN;
    return p[30:18];
  endfunction

  function automatic logic pick_led(input logic [MODE_W-1:0] mode,
                                    input slmc_led_src_t src);
    logic lit;
    case (mode)
      MODE_RUNNING:   lit = src.running;
      MODE_CONNECTED: lit = src.connected;
      MODE_ANY_BLINK: lit = (src.running || src.connected) ? src.blink : 1'b1;
      MODE_POWER:     lit = 1'b1;
      MODE_VREF:      lit = src.ref_on;
      MODE_TX:        lit = src.tx;
      MODE_RX:        lit = src.rx;
      MODE_TXRX:      lit = src.tx || src.rx;
      default:        lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

`default_nettype wire

### rtl/core/slmc_in_if.sv
`default_nettype none

interface slmc_in_if;
  import slmc_pkg::*;

  logic     valid;
  logic     ready;
  slmc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/slmc_out_if.sv
`default_nettype none

interface slmc_out_if;
  import slmc_pkg::*;

  logic      valid;
  logic      ready;
  slmc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/slmc_cfg_if.sv
`default_nettype none

interface slmc_cfg_if;
  import slmc_pkg::*;

  logic      valid;
  logic      ready;
  slmc_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/status_led_mode_controller_core.sv
// Status LED mode controller.
// in_ch carries event beats: tick, UART tx/rx notice with byte count, or a write
// of the probe running/connected flag. Only a tick produces a beat on out_ch,
// carrying both LED levels, the last measured reference in mV and the
// reference-good state after that tick.
// cfg_ch writes the reference setting (index 0) and the LED modes (1, 2); it
// is always ready and takes effect for any event accepted afterwards.
// Pipeline: a tick beat is captured in the input register, evaluated there and
// its result captured in the result register, which drives out_ch. Throughput
// is one event per cycle, a tick only when the result register is free, set by
// the single evaluation pass between those two registers.
// When out_ch stalls with a result held, non-tick events still flow; a tick
// waits in the input register and in_ch.ready drops until the result drains.
// Synchronous active-low reset clears all event state, the pipeline valids,
// sets the reference setting to 3300 mV and both LED modes to off.
`default_nettype none

module status_led_mode_controller_core #(
  parameter int unsigned BLINK_HALF_TICKS = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  slmc_in_if.sink     in_ch,
  slmc_out_if.source  out_ch,
  slmc_cfg_if.sink    cfg_ch
);
  import slmc_pkg::*;

  localparam int unsigned PHASE_W = (BLINK_HALF_TICKS > 1) ? $clog2(2 * BLINK_HALF_TICKS) : 1;
  localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(BLINK_HALF_TICKS);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * BLINK_HALF_TICKS - 1);

  logic                s1_valid_r;
  slmc_in_t            s1_data_r;
  logic                out_valid_r;
  slmc_out_t           out_data_r;

  logic [MV_W-1:0]     on_thr_r;
  logic [MV_W-1:0]     off_thr_r;
  logic [MODE_W-1:0]   led_one_mode_r;
  logic [MODE_W-1:0]   led_two_mode_r;

  logic [PHASE_W-1:0]  phase_r;
  logic [PHASE_W-1:0]  phase_nxt;
  logic                tx_pend_r;
  logic                rx_pend_r;
  logic                ref_on_r;
  logic                ref_on_nxt;
  logic                running_r;
  logic                connected_r;
  logic [MV_W-1:0]     mv_r;
  logic [MV_W-1:0]     mv_nxt;
  logic [MV_W-1:0]     sample_mv;

  logic                s1_is_tick;
  logic                out_free;
  logic                s1_go;
  logic                tick_go;
  slmc_led_src_t       led_src;
  slmc_out_t           out_nxt;

  assign cfg_ch.ready = 1'b1;

  assign s1_is_tick   = (s1_data_r.kind == KIND_TICK);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_go        = s1_valid_r && (!s1_is_tick || out_free);
  assign tick_go      = s1_go && s1_is_tick;
  assign in_ch.ready  = !s1_valid_r || s1_go;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    sample_mv  = sample_to_mv(s1_data_r.adc_sample);
    mv_nxt     = mv_r;
    ref_on_nxt = ref_on_r;
    if (s1_data_r.adc_valid) begin
      mv_nxt = sample_mv;
      if (ref_on_r) begin
        ref_on_nxt = !(sample_mv < off_thr_r);
      end else begin
        ref_on_nxt = (sample_mv >= on_thr_r);
      end
    end
    phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + PHASE_W'(1);
  end

  always_comb begin
    led_src.running   = running_r;
    led_src.connected = connected_r;
    led_src.ref_on    = ref_on_nxt;
    led_src.blink     = (phase_r < PHASE_HALF);
    led_src.tx        = tx_pend_r;
    led_src.rx        = rx_pend_r;
    out_nxt.led_one_on     = pick_led(led_one_mode_r, led_src);
    out_nxt.led_two_on     = pick_led(led_two_mode_r, led_src);
    out_nxt.external_mv    = mv_nxt;
    out_nxt.reference_good = ref_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r       <= on_threshold(SETTING_RESET);
      off_thr_r      <= off_threshold(SETTING_RESET);
      led_one_mode_r <= MODE_OFF;
      led_two_mode_r <= MODE_OFF;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CFG_REFERENCE_SETTING_MV: begin
          on_thr_r  <= on_threshold(cfg_ch.data.wdata);
          off_thr_r <= off_threshold(cfg_ch.data.wdata);
        end
        CFG_LED_ONE_MODE: led_one_mode_r <= cfg_ch.data.wdata[MODE_W-1:0];
        CFG_LED_TWO_MODE: led_two_mode_r <= cfg_ch.data.wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_data_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      tx_pend_r   <= 1'b0;
      rx_pend_r   <= 1'b0;
      ref_on_r    <= 1'b0;
      running_r   <= 1'b0;
      connected_r <= 1'b0;
      mv_r        <= '0;
    end else if (s1_go) begin
      case (s1_data_r.kind)
        KIND_TICK: begin
          phase_r   <= phase_nxt;
          tx_pend_r <= 1'b0;
          rx_pend_r <= 1'b0;
          ref_on_r  <= ref_on_nxt;
          mv_r      <= mv_nxt;
        end
        KIND_TX_NOTICE: begin
          if (s1_data_r.byte_count != '0) begin
            tx_pend_r <= 1'b1;
          end
        end
        KIND_RX_NOTICE: begin
          if (s1_data_r.byte_count != '0) begin
            rx_pend_r <= 1'b1;
          end
        end
        KIND_SET_RUNNING:   running_r   <= s1_data_r.flag_value;
        KIND_SET_CONNECTED: connected_r <= s1_data_r.flag_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
